/* rtl/srb_pkg.sv */
package srb_pkg;

  localparam int BUFFER_SIZE = 16;  // power of two: slot = id mod BUFFER_SIZE
  localparam int SLOT_W      = $clog2(BUFFER_SIZE);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int ID_W        = 31;
  localparam int PAY_W       = 32;
  localparam int NE_W        = ID_W + 1;  // next expected id can reach 2^31
  localparam int LIMIT_W     = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_REORDER_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_LIMIT      = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]  chunk_id;
    logic [PAY_W-1:0] payload;
  } item_t;

  typedef struct packed {
    logic                      reorder_enable;
    logic signed [LIMIT_W-1:0] start_limit;
    logic signed [LIMIT_W-1:0] end_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARRIVE,
    S_JUMP,
    S_DRAIN,
    S_PLACE
  } state_t;

endpackage

/* rtl/srb_chunk_if.sv */
interface srb_chunk_if;
  logic                     valid;
  logic                     ready;
  logic [srb_pkg::ID_W-1:0]  chunk_id;
  logic [srb_pkg::PAY_W-1:0] payload;

  modport source(output valid, chunk_id, payload, input ready);
  modport sink(input valid, chunk_id, payload, output ready);
endinterface

/* rtl/srb_result_if.sv */
interface srb_result_if;
  logic                     valid;
  logic                     ready;
  logic [srb_pkg::ID_W-1:0]  out_id;
  logic [srb_pkg::PAY_W-1:0] out_payload;
  logic                     last;

  modport source(output valid, out_id, out_payload, last, input ready);
  modport sink(input valid, out_id, out_payload, last, output ready);
endinterface

/* rtl/srb_front.sv */
module srb_front (
  input  logic           clk,
  input  logic           rst,
  srb_chunk_if.sink      chunks,
  output srb_pkg::item_t q_item,
  output logic           q_valid,
  input  logic           q_pop
);

  srb_pkg::item_t                fifo_mem [srb_pkg::QUEUE_DEPTH];
  logic [srb_pkg::QPTR_W-1:0]    wr_ptr;
  logic [srb_pkg::QPTR_W-1:0]    rd_ptr;
  logic [srb_pkg::QCNT_W-1:0]    count;
  logic                          push;
  logic                          pop;

  assign chunks.ready = (count != srb_pkg::QCNT_W'(srb_pkg::QUEUE_DEPTH));
  assign push         = chunks.valid && chunks.ready;
  assign q_valid      = (count != '0);
  assign pop          = q_pop && q_valid;
  assign q_item       = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= '{chunk_id: chunks.chunk_id, payload: chunks.payload};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/srb_back.sv */
module srb_back (
  input  logic           clk,
  input  logic           rst,
  input  srb_pkg::cfg_t  cfg,
  input  srb_pkg::item_t q_item,
  input  logic           q_valid,
  output logic           q_pop,
  srb_result_if.source   played
);

  localparam int B      = srb_pkg::BUFFER_SIZE;
  localparam int SLOT_W = srb_pkg::SLOT_W;
  localparam int CNT_W  = srb_pkg::CNT_W;
  localparam int ID_W   = srb_pkg::ID_W;
  localparam int PAY_W  = srb_pkg::PAY_W;
  localparam int NE_W   = srb_pkg::NE_W;

  srb_pkg::state_t   state;
  srb_pkg::state_t   state_next;
  srb_pkg::item_t    cur;

  logic [NE_W-1:0]   ne;
  logic              ne_set;
  logic [B-1:0]      slot_valid;
  logic [ID_W-1:0]   slot_id  [B];
  logic [PAY_W-1:0]  slot_pay [B];

  logic [CNT_W-1:0]  jcnt;
  logic              big;
  logic [CNT_W-1:0]  dcnt;
  logic              placed;

  logic              pend_v;
  logic [ID_W-1:0]   pend_id;
  logic [PAY_W-1:0]  pend_pay;
  logic              out_v;
  logic [ID_W-1:0]   out_id;
  logic [PAY_W-1:0]  out_pay;
  logic              out_last;

  logic [NE_W-1:0]   v32;
  logic [NE_W-1:0]   ne_eff;
  logic [NE_W-1:0]   ne_inc;
  logic [NE_W-1:0]   lim;
  logic [NE_W-1:0]   span;
  logic              big_span;
  logic [CNT_W-1:0]  visits;
  logic              is_old;
  logic              is_jump;
  logic              is_hit;
  logic              next_busy;
  logic [SLOT_W-1:0] in_slot;
  logic [SLOT_W-1:0] rd_slot;
  logic              rd_valid;
  logic [ID_W-1:0]   rd_id;
  logic [PAY_W-1:0]  rd_pay;
  logic              drain_more;

  logic              emit_req;
  logic [ID_W-1:0]   emit_id;
  logic [PAY_W-1:0]  emit_pay;
  logic              out_free;
  logic              go;
  logic              flush;

  function automatic logic in_range(input logic [ID_W-1:0] id, input srb_pkg::cfg_t c);
    logic signed [srb_pkg::LIMIT_W-1:0] idv;
    logic lo_ok;
    logic hi_ok;
    idv   = $signed({1'b0, id});
    lo_ok = (c.start_limit == '1) || (idv >= c.start_limit);
    hi_ok = (c.end_limit == '1) || (idv <= c.end_limit);
    return lo_ok && hi_ok;
  endfunction

  // classification of the current chunk against the window
  assign v32        = {1'b0, cur.chunk_id};
  assign ne_eff     = ne_set ? ne : v32;
  assign ne_inc     = ne_eff + NE_W'(1);
  assign lim        = ne_eff + NE_W'(B);
  assign is_old     = ne_set && (v32 < ne);
  assign is_jump    = (v32 >= lim);
  assign is_hit     = (v32 == ne_eff);
  assign span       = v32 - ne_eff - NE_W'(B - 1);
  assign big_span   = (span > NE_W'(B));
  assign visits     = big_span ? CNT_W'(B) : span[CNT_W-1:0];
  assign next_busy  = slot_valid[ne_inc[SLOT_W-1:0]];
  assign in_slot    = cur.chunk_id[SLOT_W-1:0];

  assign rd_slot    = ne[SLOT_W-1:0];
  assign rd_valid   = slot_valid[rd_slot];
  assign rd_id      = slot_id[rd_slot];
  assign rd_pay     = slot_pay[rd_slot];
  assign drain_more = rd_valid && (dcnt != CNT_W'(B));

  assign out_free   = !out_v || played.ready;
  assign go         = !emit_req || !pend_v || out_free;
  assign flush      = (state == srb_pkg::S_IDLE) && pend_v && out_free;

  assign played.valid       = out_v;
  assign played.out_id      = out_id;
  assign played.out_payload = out_pay;
  assign played.last        = out_last;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      srb_pkg::S_IDLE: begin
        if (q_valid && (!pend_v || out_free)) begin
          state_next = srb_pkg::S_ARRIVE;
        end
      end
      srb_pkg::S_ARRIVE: begin
        if (go) begin
          priority if (is_old) begin
            state_next = srb_pkg::S_IDLE;
          end else if (is_jump) begin
            state_next = srb_pkg::S_JUMP;
          end else if (is_hit && next_busy) begin
            state_next = srb_pkg::S_DRAIN;
          end else begin
            state_next = srb_pkg::S_IDLE;
          end
        end
      end
      srb_pkg::S_JUMP: begin
        if (go && jcnt == CNT_W'(1)) begin
          state_next = srb_pkg::S_DRAIN;
        end
      end
      srb_pkg::S_DRAIN: begin
        if (go && !drain_more) begin
          state_next = placed ? srb_pkg::S_IDLE : srb_pkg::S_PLACE;
        end
      end
      srb_pkg::S_PLACE: begin
        if (go) begin
          state_next = is_hit ? srb_pkg::S_DRAIN : srb_pkg::S_IDLE;
        end
      end
      default: state_next = srb_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    emit_req = 1'b0;
    emit_id  = cur.chunk_id;
    emit_pay = cur.payload;
    q_pop    = 1'b0;
    unique case (state)
      srb_pkg::S_IDLE: begin
        q_pop = q_valid && (!pend_v || out_free);
      end
      srb_pkg::S_ARRIVE: begin
        if (!cfg.reorder_enable) begin
          emit_req = 1'b1;
        end else begin
          emit_req = !is_old && !is_jump && is_hit && in_range(cur.chunk_id, cfg);
        end
      end
      srb_pkg::S_JUMP: begin
        emit_req = rd_valid && cfg.reorder_enable && in_range(rd_id, cfg);
        emit_id  = rd_id;
        emit_pay = rd_pay;
      end
      srb_pkg::S_DRAIN: begin
        emit_req = drain_more && cfg.reorder_enable && in_range(rd_id, cfg);
        emit_id  = rd_id;
        emit_pay = rd_pay;
      end
      srb_pkg::S_PLACE: begin
        emit_req = is_hit && cfg.reorder_enable && in_range(cur.chunk_id, cfg);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      ne         <= '0;
      ne_set     <= 1'b0;
      slot_valid <= '0;
      jcnt       <= '0;
      big        <= 1'b0;
      dcnt       <= '0;
      placed     <= 1'b0;
    end else begin
      unique case (state)
        srb_pkg::S_IDLE: ;
        srb_pkg::S_ARRIVE: begin
          if (go && !is_old) begin
            ne_set <= 1'b1;
            priority if (is_jump) begin
              ne     <= ne_eff;
              jcnt   <= visits;
              big    <= big_span;
              placed <= 1'b0;
            end else if (is_hit) begin
              ne     <= ne_inc;
              dcnt   <= '0;
              placed <= 1'b1;
            end else begin
              ne <= ne_eff;
              if (!slot_valid[in_slot]) begin
                slot_valid[in_slot] <= 1'b1;
              end
            end
          end
        end
        srb_pkg::S_JUMP: begin
          if (go) begin
            if (rd_valid) begin
              slot_valid[rd_slot] <= 1'b0;
            end
            // a very large jump lands just below the new chunk after the walk
            if (jcnt == CNT_W'(1) && big) begin
              ne <= v32 - NE_W'(B - 1);
            end else if (rd_valid) begin
              ne <= {1'b0, rd_id} + NE_W'(1);
            end else begin
              ne <= ne + NE_W'(1);
            end
            jcnt <= jcnt - CNT_W'(1);
            if (jcnt == CNT_W'(1)) begin
              dcnt <= '0;
            end
          end
        end
        srb_pkg::S_DRAIN: begin
          if (go && drain_more) begin
            slot_valid[rd_slot] <= 1'b0;
            ne   <= {1'b0, rd_id} + NE_W'(1);
            dcnt <= dcnt + CNT_W'(1);
          end
        end
        srb_pkg::S_PLACE: begin
          if (go) begin
            if (is_hit) begin
              ne     <= ne + NE_W'(1);
              dcnt   <= '0;
              placed <= 1'b1;
            end else if (!slot_valid[in_slot]) begin
              slot_valid[in_slot] <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // slot payload store, written together with the valid bit; also latches the popped queue item
  always_ff @(posedge clk) begin
    if (go && !slot_valid[in_slot] && !is_old && !is_jump && !is_hit &&
        (state == srb_pkg::S_ARRIVE || state == srb_pkg::S_PLACE)) begin
      slot_id[in_slot]  <= cur.chunk_id;
      slot_pay[in_slot] <= cur.payload;
    end
    if (q_pop) begin
      cur <= q_item;
    end
  end

  // one result is held back until it is known whether it is the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      if (emit_req && go) begin
        pend_v <= 1'b1;
      end else if (flush) begin
        pend_v <= 1'b0;
      end
      if ((emit_req && go && pend_v) || flush) begin
        out_v <= 1'b1;
      end else if (played.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_req && go) begin
      pend_id  <= emit_id;
      pend_pay <= emit_pay;
    end
    if ((emit_req && go && pend_v) || flush) begin
      out_id   <= pend_id;
      out_pay  <= pend_pay;
      out_last <= flush;
    end
  end

  a_expected_slot_empty: assert property (@(posedge clk) disable iff (rst)
    (state == srb_pkg::S_IDLE && ne_set) |-> !slot_valid[ne[SLOT_W-1:0]])
    else $error("slot of next expected id holds a chunk while idle");

  a_expected_monotonic: assert property (@(posedge clk) disable iff (rst)
    $past(ne_set) |-> (ne >= $past(ne)))
    else $error("next expected id moved backwards");

  a_window_not_full: assert property (@(posedge clk) disable iff (rst)
    (state == srb_pkg::S_IDLE) |-> ($countones(slot_valid) < B))
    else $error("window full at rest");

  a_jump_count: assert property (@(posedge clk) disable iff (rst)
    (state == srb_pkg::S_JUMP) |-> (jcnt != '0 && jcnt <= CNT_W'(B)))
    else $error("jump walk count out of range");

endmodule

/* rtl/sequence_reorder_buffer_top.sv */
// An in-order chunk passes the input queue, the current-chunk register, the held-back result
// register and the output register; the sequencer pops the next chunk only from its idle state.
// A chunk beyond the window walks min(id - expected - 15, 16) slots, then takes a drain pass
//   and a placement step (and a second drain pass when it lands on the expected id).
// A 2-entry input queue takes chunks while the sequencer or result port stalls, until it is full.
// Reset (synchronous, active high): empty window, expected id unset, ordering on, no limits.
module sequence_reorder_buffer_top (
  input  logic                             clk,
  input  logic                             rst,
  srb_chunk_if.sink                        chunks,
  srb_result_if.source                     played,
  input  logic                             cfg_write,
  input  logic [srb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  srb_pkg::cfg_t  cfg;
  srb_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reorder_enable <= 1'b1;
      cfg.start_limit    <= '1;
      cfg.end_limit      <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        srb_pkg::CFG_REORDER_ENABLE: cfg.reorder_enable <= cfg_data[0];
        srb_pkg::CFG_START_LIMIT:    cfg.start_limit    <= $signed(cfg_data);
        srb_pkg::CFG_END_LIMIT:      cfg.end_limit      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  srb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .chunks  (chunks),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  srb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .played  (played)
  );

endmodule
